// ===== hw/rtl/ryc_pkg.sv =====
// ============================================================================
// ryc_pkg
// Shared types and constants of the RGB to YUV 4:2:0 converter.
// ============================================================================
package ryc_pkg;

    localparam int unsigned PIX_W   = 8;
    localparam int unsigned COUNT_W = 12;
    localparam int unsigned SIZE_W  = 13;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'hFFF;

    localparam logic [SIZE_W-1:0] FRAME_WIDTH_RESET  = 13'd640;
    localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

    // register select: byte address bit 2
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic [PIX_W-1:0] LUMA_OFFSET   = 8'd16;
    localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
    localparam logic [16:0]      ROUND_BIAS    = 17'd128;

    typedef enum logic [1:0]
    {
        CHROMA_NONE = 2'd0,
        CHROMA_U    = 2'd1,
        CHROMA_V    = 2'd2
    } ryc_chroma_kind_t;

    typedef struct packed
    {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        ryc_chroma_kind_t kind;
        logic             frame_end;
    } ryc_job_t;

    typedef struct packed
    {
        logic [14:0]      yr;   // 66 R
        logic [15:0]      yg;   // 129 G
        logic [12:0]      yb;   // 25 B
        logic [13:0]      ur;   // 38 R
        logic [14:0]      ug;   // 74 G
        logic [14:0]      ub;   // 112 B
        logic [14:0]      vr;   // 112 R
        logic [14:0]      vg;   // 94 G
        logic [12:0]      vb;   // 18 B
        ryc_chroma_kind_t kind;
        logic             frame_end;
    } ryc_prod_t;

endpackage

// ===== hw/rtl/ryc_if.sv =====
// ============================================================================
// ryc_pix_if / ryc_yuv_if
// Valid/ready channels for RGB pixels and tagged YUV results.
// ============================================================================
interface ryc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ryc_yuv_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma;
    logic [1:0] chroma_kind;
    logic       frame_end;

    modport source (output valid, output luma, output chroma, output chroma_kind,
                    output frame_end, input ready);
    modport sink   (input valid, input luma, input chroma, input chroma_kind,
                    input frame_end, output ready);
endinterface

// ===== hw/rtl/ryc_front.sv =====
// ============================================================================
// ryc_front
// Accepts pixels, tracks column and row, tags chroma kind and frame end.
// ============================================================================
module ryc_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [ryc_pkg::SIZE_W-1:0]  frame_width,
    input  logic [ryc_pkg::SIZE_W-1:0]  frame_height,
    ryc_pix_if.sink                     pix,
    output logic                        push_valid,
    output ryc_pkg::ryc_job_t           push_data,
    input  logic                        push_ready
);

    logic [ryc_pkg::COUNT_W-1:0] column_count_reg;
    logic [ryc_pkg::COUNT_W-1:0] column_count_next;
    logic [ryc_pkg::COUNT_W-1:0] row_count_reg;
    logic [ryc_pkg::COUNT_W-1:0] row_count_next;
    logic                        line_end;
    logic                        last_row;
    logic                        take;

    assign pix.ready  = push_ready;
    assign push_valid = pix.valid;
    assign take       = pix.valid && push_ready;

    always_comb
    begin
        line_end = (({1'b0, column_count_reg} + 13'd1) >= frame_width)
                   || (column_count_reg == ryc_pkg::COUNT_MAX);
        last_row = (({1'b0, row_count_reg} + 13'd1) >= frame_height)
                   || (row_count_reg == ryc_pkg::COUNT_MAX);

        push_data.red       = pix.red;
        push_data.green     = pix.green;
        push_data.blue      = pix.blue;
        push_data.frame_end = line_end && last_row;
        if (column_count_reg[0])
        begin
            push_data.kind = ryc_pkg::CHROMA_NONE;
        end
        else if (row_count_reg[0])
        begin
            push_data.kind = ryc_pkg::CHROMA_V;
        end
        else
        begin
            push_data.kind = ryc_pkg::CHROMA_U;
        end

        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (take)
        begin
            if (line_end)
            begin
                column_count_next = '0;
                row_count_next    = last_row ? '0 : row_count_reg + 12'd1;
            end
            else
            begin
                column_count_next = column_count_reg + 12'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

endmodule

// ===== hw/rtl/ryc_queue.sv =====
// ============================================================================
// ryc_queue
// Short FIFO of tagged pixels between the front and the conversion pipeline.
// ============================================================================
module ryc_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    input  ryc_pkg::ryc_job_t push_data,
    output logic              push_ready,
    output logic              pop_valid,
    output ryc_pkg::ryc_job_t pop_data,
    input  logic              pop_ready
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    ryc_pkg::ryc_job_t slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/ryc_back.sv =====
// ============================================================================
// ryc_back
// Two-stage BT.601 conversion: constant products, then sums, rounding and offset.
// ============================================================================
module ryc_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    input  ryc_pkg::ryc_job_t pop_data,
    output logic              pop_ready,
    ryc_yuv_if.source         yuv
);

    logic              s1_valid_reg;
    logic              s1_valid_next;
    ryc_pkg::ryc_prod_t s1_reg;
    ryc_pkg::ryc_prod_t s1_next;
    logic              s1_ready;
    logic              s2_valid_reg;
    logic              s2_valid_next;
    logic              s2_ready;
    logic [7:0]        luma_reg;
    logic [7:0]        luma_next;
    logic [7:0]        chroma_reg;
    logic [7:0]        chroma_next;
    ryc_pkg::ryc_chroma_kind_t kind_reg;
    logic              frame_end_reg;
    logic [16:0]       y_sum;
    logic [16:0]       u_sum;
    logic [16:0]       v_sum;

    assign s2_ready  = !s2_valid_reg || yuv.ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pop_ready = s1_ready;

    assign yuv.valid       = s2_valid_reg;
    assign yuv.luma        = luma_reg;
    assign yuv.chroma      = chroma_reg;
    assign yuv.chroma_kind = kind_reg;
    assign yuv.frame_end   = frame_end_reg;

    always_comb
    begin
        s1_next.yr        = 15'(pop_data.red)   * 15'd66;
        s1_next.yg        = 16'(pop_data.green) * 16'd129;
        s1_next.yb        = 13'(pop_data.blue)  * 13'd25;
        s1_next.ur        = 14'(pop_data.red)   * 14'd38;
        s1_next.ug        = 15'(pop_data.green) * 15'd74;
        s1_next.ub        = 15'(pop_data.blue)  * 15'd112;
        s1_next.vr        = 15'(pop_data.red)   * 15'd112;
        s1_next.vg        = 15'(pop_data.green) * 15'd94;
        s1_next.vb        = 13'(pop_data.blue)  * 13'd18;
        s1_next.kind      = pop_data.kind;
        s1_next.frame_end = pop_data.frame_end;

        s1_valid_next = s1_valid_reg;
        if (s1_ready)
        begin
            s1_valid_next = pop_valid;
        end

        y_sum = 17'(s1_reg.yr) + 17'(s1_reg.yg) + 17'(s1_reg.yb) + ryc_pkg::ROUND_BIAS;
        u_sum = 17'(s1_reg.ub) - 17'(s1_reg.ur) - 17'(s1_reg.ug) + ryc_pkg::ROUND_BIAS;
        v_sum = 17'(s1_reg.vr) - 17'(s1_reg.vg) - 17'(s1_reg.vb) + ryc_pkg::ROUND_BIAS;

        luma_next = y_sum[15:8] + ryc_pkg::LUMA_OFFSET;
        case (s1_reg.kind)
            ryc_pkg::CHROMA_U: chroma_next = u_sum[15:8] + ryc_pkg::CHROMA_OFFSET;
            ryc_pkg::CHROMA_V: chroma_next = v_sum[15:8] + ryc_pkg::CHROMA_OFFSET;
            default:           chroma_next = '0;
        endcase

        s2_valid_next = s2_valid_reg;
        if (s2_ready)
        begin
            s2_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && pop_valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            luma_reg      <= luma_next;
            chroma_reg    <= chroma_next;
            kind_reg      <= s1_reg.kind;
            frame_end_reg <= s1_reg.frame_end;
        end
    end

endmodule

// ===== hw/rtl/rgb_to_yuv420_converter_top.sv =====
// ============================================================================
// rgb_to_yuv420_converter_top
// RGB raster pixels in, BT.601 luma with point-sampled 4:2:0 chroma tags out.
// ============================================================================
// Takes one pixel per clock and returns one tagged result per pixel at the
// same sustained rate of one per cycle while yuv.ready is held high. An input
// transaction is registered in the pixel queue, then in the constant-product
// stage and, after the sum and offset, in the output register. The queue
// (QUEUE_DEPTH entries) lets the input side keep accepting while a result is
// held. Write frame_width (0x0) and frame_height (0x4) over APB only while no
// pixel is in flight.
module rgb_to_yuv420_converter_top
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    ryc_pix_if.sink                     pix,
    ryc_yuv_if.source                   yuv,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ryc_pkg::APB_AW-1:0]  paddr,
    input  logic [ryc_pkg::APB_DW-1:0]  pwdata,
    output logic [ryc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    logic [ryc_pkg::SIZE_W-1:0] frame_width_reg;
    logic [ryc_pkg::SIZE_W-1:0] frame_height_reg;
    logic                       cfg_write;
    logic                       push_valid;
    logic                       push_ready;
    ryc_pkg::ryc_job_t          push_data;
    logic                       pop_valid;
    logic                       pop_ready;
    ryc_pkg::ryc_job_t          pop_data;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        case (paddr[2])
            ryc_pkg::REG_FRAME_WIDTH:  prdata = 32'(frame_width_reg);
            ryc_pkg::REG_FRAME_HEIGHT: prdata = 32'(frame_height_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= ryc_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= ryc_pkg::FRAME_HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ryc_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[ryc_pkg::SIZE_W-1:0];
                ryc_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[ryc_pkg::SIZE_W-1:0];
                default:                   ;
            endcase
        end
    end

    ryc_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .pix          (pix),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .push_ready   (push_ready)
    );

    ryc_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop_ready  (pop_ready)
    );

    ryc_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop_ready (pop_ready),
        .yuv       (yuv)
    );

endmodule
